// ----- sv/rbg_pkg.sv -----
`default_nettype none

package rbg_pkg;

  // Products of the ratio test: 200 * current + max, and 2 * (threshold + 1) * max,
  // both stay below 2**24 for 16-bit operands.
  localparam int unsigned PROD_W = 24;

  localparam logic [7:0] LHS_SCALE = 8'd200;

  localparam int unsigned LADDER_LEN = 8;

  // p > T  <=>  200*cur + max >= 2*(T+1)*max, for T in 100, 88, ..., 16.
  localparam logic [7:0] LADDER_K [LADDER_LEN] = '{
    8'd202, 8'd178, 8'd154, 8'd130, 8'd106, 8'd82, 8'd58, 8'd34
  };

  localparam logic [7:0] BAR_PATTERNS [LADDER_LEN + 1] = '{
    8'hFF, 8'h7F, 8'h3F, 8'h1F, 8'h0F, 8'h07, 8'h03, 8'h01, 8'h00
  };

  localparam logic [7:0] SELECT_BYTES [2] = '{8'h80, 8'h40};

  // Step numbering of one transfer: 0 opens, 1..32 carry bits, 33 latches.
  localparam int unsigned STEP_W = 6;
  localparam logic [STEP_W-1:0] FIRST_BIT_STEP = 6'd1;
  localparam logic [STEP_W-1:0] LATCH_STEP = 6'd33;

  typedef struct packed {
    logic [7:0] pattern;
    logic       bar_select;
  } rbg_job_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_SEARCH,
    FE_PUSH
  } fe_state_t;

endpackage

`default_nettype wire

// ----- sv/rbg_if.sv -----
`default_nettype none

interface rbg_req_if;
  logic        valid;
  logic        ready;
  logic [15:0] current_value;
  logic [15:0] max_value;
  logic        bar_select;

  modport source (output valid, output current_value, output max_value,
                  output bar_select, input ready);
  modport sink (input valid, input current_value, input max_value,
                input bar_select, output ready);
endinterface

interface rbg_pin_if;
  logic valid;
  logic ready;
  logic latch_pin;
  logic clock_pin;
  logic data_pin;
  logic last_step;

  modport source (output valid, output latch_pin, output clock_pin,
                  output data_pin, output last_step, input ready);
  modport sink (input valid, input latch_pin, input clock_pin,
                input data_pin, input last_step, output ready);
endinterface

`default_nettype wire

// ----- sv/rbg_front.sv -----
`default_nettype none

module rbg_front
  import rbg_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  rbg_req_if.sink       req,
  output logic          push,
  input  wire logic     push_ready,
  output rbg_job_t      job
);

  fe_state_t state, state_next;

  logic [PROD_W-1:0] lhs;
  logic [15:0]       max_q;
  logic [2:0]        idx;
  logic [7:0]        pattern;
  logic              sel;

  logic [PROD_W-1:0] rhs;
  logic              hit;
  logic              accept;

  assign rhs    = PROD_W'(max_q) * PROD_W'(LADDER_K[idx]);
  assign hit    = lhs >= rhs;
  assign accept = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    push       = 1'b0;
    unique case (state)
      FE_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = FE_SEARCH;
        end
      end
      FE_SEARCH: begin
        if (hit || idx == 3'(LADDER_LEN - 1)) begin
          state_next = FE_PUSH;
        end
      end
      FE_PUSH: begin
        push = 1'b1;
        if (push_ready) begin
          state_next = FE_IDLE;
        end
      end
      default: begin
        state_next = FE_IDLE;
      end
    endcase
  end

  // Walk the ladder from the top, one threshold per cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      lhs   <= PROD_W'(req.current_value) * PROD_W'(LHS_SCALE)
             + PROD_W'(req.max_value);
      max_q <= req.max_value;
      sel   <= req.bar_select;
      idx   <= '0;
    end else if (state == FE_SEARCH) begin
      if (hit) begin
        pattern <= BAR_PATTERNS[{1'b0, idx}];
      end else if (idx == 3'(LADDER_LEN - 1)) begin
        pattern <= BAR_PATTERNS[LADDER_LEN];
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  assign job.pattern    = pattern;
  assign job.bar_select = sel;

  a_accept_search: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == FE_SEARCH && idx == '0)
    else $error("front: accepted beat did not start the ladder search");

  a_zero_max_full: assert property (@(posedge clk) disable iff (rst)
    state == FE_PUSH && max_q == '0 |-> pattern == BAR_PATTERNS[0])
    else $error("front: zero maximum did not give the full pattern");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    state == FE_PUSH && !push_ready |=> state == FE_PUSH && !req.ready)
    else $error("front: job dropped while queue was full");

endmodule

`default_nettype wire

// ----- sv/rbg_queue.sv -----
`default_nettype none

module rbg_queue
  import rbg_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  output logic          push_ready,
  input  wire rbg_job_t push_job,
  output logic          pop_valid,
  input  wire logic     pop,
  output rbg_job_t      pop_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rbg_job_t        slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = count != CW'(DEPTH);
  assign pop_valid  = count != '0;
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_job    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue: fill count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> count == $past(count) + 1'b1)
    else $error("queue: push did not grow the fill count");

  a_last_pop: assert property (@(posedge clk) disable iff (rst)
    do_pop && !do_push && count == CW'(1) |=> !pop_valid)
    else $error("queue: still valid after last entry popped");

endmodule

`default_nettype wire

// ----- sv/rbg_shifter.sv -----
`default_nettype none

module rbg_shifter
  import rbg_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     job_valid,
  output logic          job_pop,
  input  wire rbg_job_t job,
  rbg_pin_if.source     pins
);

  logic              active;
  logic [STEP_W-1:0] step;
  logic [15:0]       word;

  logic              out_valid;
  logic              latch_q;
  logic              clock_q;
  logic              data_q;
  logic              last_q;

  logic              out_free;
  logic              produce;
  logic [STEP_W-1:0] bit_step;
  logic [3:0]        bit_idx;

  assign out_free = !out_valid || pins.ready;
  assign produce  = out_free && (active || job_valid);
  assign job_pop  = produce && !active;
  assign bit_step = step - FIRST_BIT_STEP;
  assign bit_idx  = bit_step[4:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= active || job_valid;
      end
      if (produce) begin
        if (!active) begin
          active <= 1'b1;
        end else if (step == LATCH_STEP) begin
          active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      if (!active) begin
        // Opening step: all lines low; load the word to shift.
        word    <= {SELECT_BYTES[job.bar_select], job.pattern};
        step    <= FIRST_BIT_STEP;
        latch_q <= 1'b0;
        clock_q <= 1'b0;
        data_q  <= 1'b0;
        last_q  <= 1'b0;
      end else if (step == LATCH_STEP) begin
        // Latch step: data holds the last bit sent.
        latch_q <= 1'b1;
        clock_q <= 1'b0;
        data_q  <= word[15];
        last_q  <= 1'b1;
      end else begin
        step    <= step + 1'b1;
        latch_q <= 1'b0;
        clock_q <= !step[0];
        data_q  <= word[bit_idx];
        last_q  <= 1'b0;
      end
    end
  end

  assign pins.valid     = out_valid;
  assign pins.latch_pin = latch_q;
  assign pins.clock_pin = clock_q;
  assign pins.data_pin  = data_q;
  assign pins.last_step = last_q;

  a_last_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_q |-> latch_q && !clock_q)
    else $error("shifter: last beat is not a latch step");

  a_latch_ends: assert property (@(posedge clk) disable iff (rst)
    produce && active && step == LATCH_STEP |=> !active)
    else $error("shifter: transfer ran past the latch step");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> !active && job_valid)
    else $error("shifter: job taken mid transfer");

endmodule

`default_nettype wire

// ----- sv/ratio_bar_graph_serializer.sv -----
`default_nettype none

// Bar graph serializer: each request beat carries a current value, a full-scale
// value and a bar select; the block rounds 100 * current / max half up, picks
// one of nine LED patterns from the ladder 100, 88, 76, 64, 52, 40, 28, 16
// (above 100 percent, or a zero maximum, lights every LED), and then emits 34
// pin-state beats for a pair of serial shift registers: one all-low beat,
// the 8 pattern bits and then the select byte (0x80 for bar 0, 0x40 for bar 1),
// LSB first, each as a clock-low beat and a clock-high beat, and a closing
// latch-high beat flagged by last_step. The shifter sends one beat per cycle to the
// pin port unless that port stalls, and this sets the sustained rate.
// The front end walks the ladder, one compare per cycle through a 16x8 multiply,
// hands the request to the queue once the pattern is found, and is ready for the
// next request the cycle after that hand-off, so the next request is taken
// while the current transfer is still shifting.
// Pin beats leave through an output register; a stalled pin port holds the
// shifter without losing a beat.

module ratio_bar_graph_serializer
  import rbg_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst,
  rbg_req_if.sink   req,
  rbg_pin_if.source rsp
);

  logic     fe_push;
  logic     fe_push_ready;
  rbg_job_t fe_job;

  logic     q_valid;
  logic     q_pop;
  rbg_job_t q_job;

  // Classify: ratio to pattern.
  rbg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .push       (fe_push),
    .push_ready (fe_push_ready),
    .job        (fe_job)
  );

  // Hold classified jobs between the two halves.
  rbg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (fe_push),
    .push_ready (fe_push_ready),
    .push_job   (fe_job),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_job    (q_job)
  );

  // Shift out pin states, one beat per cycle unless the pin port stalls.
  rbg_shifter u_shifter (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job_pop   (q_pop),
    .job       (q_job),
    .pins      (rsp)
  );

endmodule

`default_nettype wire
